FILE: rtl/rbl_pkg.sv
package rbl_pkg;

    // Register map of the configuration port
    localparam logic [1:0] REG_SMOOTHING_WEIGHT = 2'd0;
    localparam logic [1:0] REG_UPPER_THRESHOLD  = 2'd1;
    localparam logic [1:0] REG_LOWER_THRESHOLD  = 2'd2;
    localparam logic [1:0] REG_HYSTERESIS       = 2'd3;

    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W  = 9;

    // Field widths
    localparam int WEIGHT_W = 9;
    localparam int DBM_W    = 8;
    localparam int HYST_W   = 5;
    localparam int LEVEL_W  = 16;
    localparam int BAR_W    = 2;

    // Weight is Q1.8, so full weight is 256
    localparam int                  WEIGHT_FRAC = 8;
    localparam logic [WEIGHT_W-1:0] WEIGHT_ONE  = 9'd256;

    // Bar codes
    localparam logic [BAR_W-1:0] BARS_NONE  = 2'd0;
    localparam logic [BAR_W-1:0] BARS_ONE   = 2'd1;
    localparam logic [BAR_W-1:0] BARS_TWO   = 2'd2;
    localparam logic [BAR_W-1:0] BARS_THREE = 2'd3;

    // Configuration register set
    typedef struct packed {
        logic [WEIGHT_W-1:0] weight;
        logic [DBM_W-1:0]    upper;
        logic [DBM_W-1:0]    lower;
        logic [HYST_W-1:0]   hyst;
    } t_cfg;

    localparam t_cfg CFG_RESET = '{
        weight: 9'd51,
        upper:  8'hC4,   // -60 dBm
        lower:  8'hB5,   // -75 dBm
        hyst:   5'd4
    };

endpackage

FILE: rtl/rbl_ema.sv
module rbl_ema #(
    parameter int FRACTION_BITS = 8
) (
    input  logic                                   i_first,
    input  logic signed [rbl_pkg::DBM_W-1:0]       i_sample,
    input  logic signed [rbl_pkg::LEVEL_W-1:0]     i_old,
    input  logic        [rbl_pkg::WEIGHT_W-1:0]    i_weight,
    output logic signed [rbl_pkg::LEVEL_W-1:0]     o_level
);
    import rbl_pkg::*;

    localparam int S_W = DBM_W + FRACTION_BITS;
    localparam int D_W = ((S_W > LEVEL_W) ? S_W : LEVEL_W) + 1;
    localparam int P_W = D_W + WEIGHT_W + 1;

    localparam logic signed [P_W-1:0] LEVEL_MAX = P_W'(32767);
    localparam logic signed [P_W-1:0] LEVEL_MIN = -P_W'(32768);

    logic signed [S_W-1:0]      s_fx;
    logic        [WEIGHT_W-1:0] w_eff;
    logic signed [D_W-1:0]      diff;
    logic signed [P_W-1:0]      prod;
    logic signed [P_W-1:0]      step;
    logic signed [P_W-1:0]      pre;

    // Sample in fixed point
    assign s_fx = {i_sample, {FRACTION_BITS{1'b0}}};

    // Weight above one acts as one
    assign w_eff = i_weight[WEIGHT_W-1] ? WEIGHT_ONE : i_weight;

    // old + floor((sample - old) * w / 256), same as the weighted sum form
    assign diff = D_W'(s_fx) - D_W'(i_old);
    assign prod = P_W'(diff) * $signed({1'b0, w_eff});
    assign step = (prod >>> WEIGHT_FRAC) + P_W'(i_old);

    // First beat after link-up loads the sample directly
    assign pre = i_first ? P_W'(s_fx) : step;

    // Saturate to 16 bits
    always_comb begin
        if (pre > LEVEL_MAX) begin
            o_level = 16'sh7FFF;
        end else if (pre < LEVEL_MIN) begin
            o_level = 16'sh8000;
        end else begin
            o_level = pre[LEVEL_W-1:0];
        end
    end

endmodule

FILE: rtl/rbl_bars.sv
module rbl_bars #(
    parameter int FRACTION_BITS = 8
) (
    input  logic signed [rbl_pkg::LEVEL_W-1:0] i_level,
    input  logic        [rbl_pkg::BAR_W-1:0]   i_last,
    input  rbl_pkg::t_cfg                      i_cfg,
    output logic        [rbl_pkg::BAR_W-1:0]   o_bars
);
    import rbl_pkg::*;

    localparam int C_W = ((DBM_W + FRACTION_BITS + 2) > LEVEL_W) ?
                         (DBM_W + FRACTION_BITS + 2) : LEVEL_W;

    logic signed [C_W-1:0] lvl;
    logic signed [C_W-1:0] up;
    logic signed [C_W-1:0] lo;
    logic signed [C_W-1:0] h;
    logic signed [C_W-1:0] up_minus;
    logic signed [C_W-1:0] up_plus;
    logic signed [C_W-1:0] lo_minus;
    logic signed [C_W-1:0] lo_plus;

    // Thresholds scaled to the level's fixed-point format
    assign lvl      = C_W'(i_level);
    assign up       = C_W'($signed(i_cfg.upper)) <<< FRACTION_BITS;
    assign lo       = C_W'($signed(i_cfg.lower)) <<< FRACTION_BITS;
    assign h        = $signed(C_W'(i_cfg.hyst)) <<< FRACTION_BITS;
    assign up_minus = up - h;
    assign up_plus  = up + h;
    assign lo_minus = lo - h;
    assign lo_plus  = lo + h;

    // Plain placement with no prior level, hysteresis otherwise
    always_comb begin
        o_bars = i_last;
        case (i_last)
            BARS_NONE: begin
                if (lvl >= up) begin
                    o_bars = BARS_THREE;
                end else if (lvl >= lo) begin
                    o_bars = BARS_TWO;
                end else begin
                    o_bars = BARS_ONE;
                end
            end
            BARS_THREE: begin
                if (lvl < up_minus) begin
                    o_bars = BARS_TWO;
                end
            end
            BARS_ONE: begin
                if (lvl >= lo_plus) begin
                    o_bars = BARS_TWO;
                end
            end
            default: begin
                if (lvl >= up_plus) begin
                    o_bars = BARS_THREE;
                end else if (lvl < lo_minus) begin
                    o_bars = BARS_ONE;
                end
            end
        endcase
    end

endmodule

FILE: rtl/rssi_bar_level_hysteresis.sv
// Signal-strength bar indicator.
// Input channel (i_in_valid / o_in_stall) carries one beat per sample: the
// link-up flag and the strength in whole dBm. Output channel (o_out_valid /
// i_out_stall) returns one beat per input beat: bar count 0..3 and the
// smoothed level in signed fixed point with FRACTION_BITS fraction bits.
// A taken beat sits in the input register; its average, placement and
// state update happen when it moves to the output register. Throughput
// is one beat per cycle while the receiver does not stall.
// The moving average keeps its state in a register fed back into the same
// cycle, so consecutive beats follow each other without a gap.
// Configuration writes (i_cfg_we) take effect at the next edge.
// Reset (synchronous, active low) empties both registers, clears the
// average and last bar count, and restores the configuration defaults
// (weight 51, thresholds -60 and -75 dBm, hysteresis 4 dB).
// When the receiver stalls, the output beat holds; the input register
// still takes one more beat and then o_in_stall rises until the output
// beat is taken.
module rssi_bar_level_hysteresis #(
    parameter int FRACTION_BITS = 8
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    // Configuration
    input  logic                                  i_cfg_we,
    input  logic [rbl_pkg::CFG_INDEX_W-1:0]       i_cfg_index,
    input  logic [rbl_pkg::CFG_DATA_W-1:0]        i_cfg_data,
    // Input channel
    input  logic                                  i_in_valid,
    output logic                                  o_in_stall,
    input  logic                                  i_link_up,
    input  logic signed [rbl_pkg::DBM_W-1:0]      i_sample_dbm,
    // Output channel
    output logic                                  o_out_valid,
    input  logic                                  i_out_stall,
    output logic [rbl_pkg::BAR_W-1:0]             o_bar_level,
    output logic signed [rbl_pkg::LEVEL_W-1:0]    o_smoothed_level_out
);
    import rbl_pkg::*;

    t_cfg                       r_cfg;

    logic                       r_in_valid;
    logic                       r_link;
    logic signed [DBM_W-1:0]    r_sample;

    logic                       r_out_valid;
    logic [BAR_W-1:0]           r_bars_out;
    logic signed [LEVEL_W-1:0]  r_level_out;

    logic signed [LEVEL_W-1:0]  r_level;
    logic                       r_avg_valid;
    logic [BAR_W-1:0]           r_last_bars;

    logic signed [LEVEL_W-1:0]  ema_level;
    logic [BAR_W-1:0]           place_bars;
    logic signed [LEVEL_W-1:0]  n_level;
    logic                       n_avg_valid;
    logic [BAR_W-1:0]           n_bars;

    logic                       advance;
    logic                       in_take;
    logic                       fire;

    // Handshake
    assign advance    = !r_out_valid || !i_out_stall;
    assign o_in_stall = r_in_valid && !advance;
    assign in_take    = i_in_valid && !o_in_stall;
    assign fire       = r_in_valid && advance;

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= CFG_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                REG_SMOOTHING_WEIGHT: r_cfg.weight <= i_cfg_data;
                REG_UPPER_THRESHOLD:  r_cfg.upper  <= i_cfg_data[DBM_W-1:0];
                REG_LOWER_THRESHOLD:  r_cfg.lower  <= i_cfg_data[DBM_W-1:0];
                REG_HYSTERESIS:       r_cfg.hyst   <= i_cfg_data[HYST_W-1:0];
                default: ;
            endcase
        end
    end

    // Input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (!o_in_stall) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_link   <= i_link_up;
            r_sample <= i_sample_dbm;
        end
    end

    // Averaging and placement
    rbl_ema #(
        .FRACTION_BITS (FRACTION_BITS)
    ) u_ema (
        .i_first  (!r_avg_valid),
        .i_sample (r_sample),
        .i_old    (r_level),
        .i_weight (r_cfg.weight),
        .o_level  (ema_level)
    );

    rbl_bars #(
        .FRACTION_BITS (FRACTION_BITS)
    ) u_bars (
        .i_level (ema_level),
        .i_last  (r_last_bars),
        .i_cfg   (r_cfg),
        .o_bars  (place_bars)
    );

    // Link down clears the average and last bar count and reports no link
    always_comb begin
        if (r_link) begin
            n_level     = ema_level;
            n_avg_valid = 1'b1;
            n_bars      = place_bars;
        end else begin
            n_level     = '0;
            n_avg_valid = 1'b0;
            n_bars      = BARS_NONE;
        end
    end

    // Average state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_level     <= '0;
            r_avg_valid <= 1'b0;
            r_last_bars <= BARS_NONE;
        end else if (fire) begin
            r_level     <= n_level;
            r_avg_valid <= n_avg_valid;
            r_last_bars <= n_bars;
        end
    end

    // Output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= r_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (fire) begin
            r_bars_out  <= n_bars;
            r_level_out <= n_level;
        end
    end

    assign o_out_valid          = r_out_valid;
    assign o_bar_level          = r_bars_out;
    assign o_smoothed_level_out = r_level_out;

endmodule
